FILE: rtl/lia_pkg.sv
package lia_pkg;

  localparam int NUM_IDS    = 256;
  localparam int ID_W       = 9;
  localparam int FIFO_AW    = 8;
  localparam int NUM_LEVELS = 16;
  localparam int LVL_W      = 4;
  localparam int OP_W       = 3;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_REM   = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT  = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ADD_LNK,
    S_REM_RD,
    S_REM_CHK,
    S_NXT_LD,
    S_NXT_STEP,
    S_NXT_WAIT
  } state_t;

  typedef enum logic [2:0] {
    RK_PLAIN,
    RK_ADD,
    RK_FERR,
    RK_REM_HIT,
    RK_NXT_HIT,
    RK_END
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      take;
    logic      add_link;
    logic      walk_head;
    logic      head_cur;
    logic      rem_adv;
    logic      rem_unlink;
    logic      nxt_adv;
    logic      nxt_lvl;
    logic      cur_clear;
    logic      flag_set;
    logic      emit;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fifo_empty;
    logic            id_bad;
    logic            cur_zero;
    logic            cur_eq_id;
    logic            n_eq_ent;
    logic            lvl_last;
  } sts_t;

endpackage

FILE: rtl/lia_ctrl.sv
module lia_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  lia_pkg::sts_t sts,
  output lia_pkg::cmd_t cmd,
  output logic          busy
);

  lia_pkg::state_t state_r;
  lia_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lia_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lia_pkg::S_IDLE: begin
        if (start) state_nxt = lia_pkg::S_DISP;
      end
      lia_pkg::S_DISP: begin
        state_nxt = lia_pkg::S_IDLE;
        case (sts.op)
          lia_pkg::OP_ADD: begin
            if (!sts.fifo_empty) state_nxt = lia_pkg::S_ADD_LNK;
          end
          lia_pkg::OP_REM: begin
            if (!sts.id_bad) state_nxt = lia_pkg::S_REM_RD;
          end
          lia_pkg::OP_NEXT: state_nxt = lia_pkg::S_NXT_STEP;
          default: state_nxt = lia_pkg::S_IDLE;
        endcase
      end
      lia_pkg::S_ADD_LNK: state_nxt = lia_pkg::S_IDLE;
      lia_pkg::S_REM_RD: begin
        state_nxt = sts.cur_zero ? lia_pkg::S_IDLE : lia_pkg::S_REM_CHK;
      end
      lia_pkg::S_REM_CHK: begin
        state_nxt = sts.cur_eq_id ? lia_pkg::S_IDLE : lia_pkg::S_REM_RD;
      end
      lia_pkg::S_NXT_LD: state_nxt = lia_pkg::S_NXT_STEP;
      lia_pkg::S_NXT_STEP: begin
        if (sts.cur_zero) begin
          state_nxt = sts.lvl_last ? lia_pkg::S_IDLE : lia_pkg::S_NXT_LD;
        end else if (sts.n_eq_ent) begin
          state_nxt = lia_pkg::S_IDLE;
        end else begin
          state_nxt = lia_pkg::S_NXT_WAIT;
        end
      end
      lia_pkg::S_NXT_WAIT: state_nxt = lia_pkg::S_NXT_STEP;
      default: state_nxt = lia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = lia_pkg::RK_PLAIN;
    busy     = (state_r != lia_pkg::S_IDLE);
    case (state_r)
      lia_pkg::S_IDLE: begin
        cmd.load = start;
      end
      lia_pkg::S_DISP: begin
        case (sts.op)
          lia_pkg::OP_ADD: begin
            if (sts.fifo_empty) begin
              cmd.emit = 1'b1;
              cmd.kind = lia_pkg::RK_FERR;
            end else begin
              cmd.take = 1'b1;
            end
          end
          lia_pkg::OP_REM: begin
            if (sts.id_bad) cmd.emit = 1'b1;
            else cmd.walk_head = 1'b1;
          end
          lia_pkg::OP_START: begin
            cmd.cur_clear = 1'b1;
            cmd.emit      = 1'b1;
          end
          lia_pkg::OP_NEXT: begin
            cmd.walk_head = 1'b1;
            cmd.head_cur  = 1'b1;
          end
          lia_pkg::OP_MARK: begin
            cmd.flag_set = 1'b1;
            cmd.emit     = 1'b1;
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      lia_pkg::S_ADD_LNK: begin
        cmd.add_link = 1'b1;
        cmd.emit     = 1'b1;
        cmd.kind     = lia_pkg::RK_ADD;
      end
      lia_pkg::S_REM_RD: begin
        cmd.emit = sts.cur_zero;
      end
      lia_pkg::S_REM_CHK: begin
        if (sts.cur_eq_id) begin
          cmd.rem_unlink = 1'b1;
          cmd.emit       = 1'b1;
          cmd.kind       = lia_pkg::RK_REM_HIT;
        end else begin
          cmd.rem_adv = 1'b1;
        end
      end
      lia_pkg::S_NXT_LD: begin
        cmd.walk_head = 1'b1;
        cmd.head_cur  = 1'b1;
      end
      lia_pkg::S_NXT_STEP: begin
        if (sts.cur_zero) begin
          if (sts.lvl_last) begin
            cmd.emit = 1'b1;
            cmd.kind = lia_pkg::RK_END;
          end else begin
            cmd.nxt_lvl = 1'b1;
          end
        end else if (sts.n_eq_ent) begin
          cmd.emit = 1'b1;
          cmd.kind = lia_pkg::RK_NXT_HIT;
        end
      end
      lia_pkg::S_NXT_WAIT: begin
        cmd.nxt_adv = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/lia_dp.sv
module lia_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lia_pkg::OP_W-1:0]     in_op,
  input  logic [lia_pkg::LVL_W-1:0]    in_level,
  input  logic [lia_pkg::ID_W-1:0]     in_item_id,
  input  lia_pkg::cmd_t                cmd,
  output lia_pkg::sts_t                sts,
  output logic                         out_valid,
  output logic [lia_pkg::ID_W-1:0]     out_result_id,
  output logic                         out_hit,
  output logic                         out_full_error,
  output logic                         out_end_reached,
  output logic                         out_ready_flag
);

  localparam int IW = lia_pkg::ID_W;
  localparam int AW = lia_pkg::FIFO_AW;
  localparam int LW = lia_pkg::LVL_W;

  // latched item
  logic [lia_pkg::OP_W-1:0] op_r;
  logic [LW-1:0]            lvl_r;
  logic [IW-1:0]            id_r;

  // free ID ring; a slot at or above wr_fill_r reads as its index + 1 instead of memory
  logic [IW-1:0] fifo_mem [lia_pkg::NUM_IDS];
  logic [IW-1:0] fifo_q_r;
  logic [AW-1:0] fq_idx_r;
  logic          fq_valid_r;
  logic [AW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] free_count_r, free_count_nxt;
  logic [IW-1:0] wr_fill_r, wr_fill_nxt;

  logic [IW-1:0] link_mem [lia_pkg::NUM_IDS+1];
  logic [IW-1:0] link_q_r;

  logic [IW-1:0] lhead_r [lia_pkg::NUM_LEVELS];
  logic [IW-1:0] ltail_r [lia_pkg::NUM_LEVELS];

  logic [LW-1:0] cur_lvl_r, cur_lvl_nxt;
  logic [IW-1:0] cur_ent_r, cur_ent_nxt;
  logic          flag_r, flag_nxt;

  logic [IW-1:0] wcur_r, wcur_nxt;
  logic [IW-1:0] wprev_r, wprev_nxt;
  logic [IW-1:0] wn_r, wn_nxt;
  logic [IW-1:0] nid_r, nid_nxt;

  logic [IW-1:0] fifo_val;
  logic [LW-1:0] hsel;
  logic [IW-1:0] head_rd, tail_rd;

  logic          lw_en;
  logic [IW-1:0] lw_addr, lw_data;
  logic          fw_en;
  logic [AW-1:0] fw_idx;
  logic          lh_we, lt_we;
  logic [IW-1:0] lh_data, lt_data;

  logic          out_valid_r;
  logic [IW-1:0] out_id_r;
  logic          out_hit_r, out_ferr_r, out_end_r, out_rdy_r;

  assign fifo_val = fq_valid_r ? fifo_q_r : ({1'b0, fq_idx_r} + IW'(1));
  assign hsel     = cmd.head_cur ? cur_lvl_r : lvl_r;
  assign head_rd  = lhead_r[hsel];
  assign tail_rd  = ltail_r[lvl_r];

  assign sts.op         = op_r;
  assign sts.fifo_empty = (free_count_r == '0);
  assign sts.id_bad     = (id_r == '0) || (id_r > IW'(lia_pkg::NUM_IDS));
  assign sts.cur_zero   = (wcur_r == '0);
  assign sts.cur_eq_id  = (wcur_r == id_r);
  assign sts.n_eq_ent   = (wn_r == cur_ent_r);
  assign sts.lvl_last   = (cur_lvl_r == LW'(lia_pkg::NUM_LEVELS - 1));

  always_comb begin
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    wr_fill_nxt    = wr_fill_r;
    cur_lvl_nxt    = cur_lvl_r;
    cur_ent_nxt    = cur_ent_r;
    flag_nxt       = flag_r;
    wcur_nxt       = wcur_r;
    wprev_nxt      = wprev_r;
    wn_nxt         = wn_r;
    nid_nxt        = nid_r;
    lw_en          = 1'b0;
    lw_addr        = wcur_r;
    lw_data        = '0;
    fw_en          = 1'b0;
    fw_idx         = free_head_r + free_count_r[AW-1:0];
    lh_we          = 1'b0;
    lh_data        = '0;
    lt_we          = 1'b0;
    lt_data        = '0;

    if (cmd.take) begin
      nid_nxt        = fifo_val;
      free_head_nxt  = free_head_r + AW'(1);
      free_count_nxt = free_count_r - IW'(1);
      lw_en          = 1'b1;
      lw_addr        = fifo_val;
      lw_data        = '0;
    end
    if (cmd.add_link) begin
      if (tail_rd == '0) begin
        lh_we   = 1'b1;
        lh_data = nid_r;
      end else begin
        lw_en   = 1'b1;
        lw_addr = tail_rd;
        lw_data = nid_r;
      end
      lt_we   = 1'b1;
      lt_data = nid_r;
    end
    if (cmd.walk_head) begin
      wcur_nxt  = head_rd;
      wprev_nxt = '0;
      wn_nxt    = '0;
    end
    if (cmd.rem_adv) begin
      wprev_nxt = wcur_r;
      wcur_nxt  = link_q_r;
    end
    if (cmd.rem_unlink) begin
      if (wprev_r == '0) begin
        lh_we   = 1'b1;
        lh_data = link_q_r;
      end else begin
        lw_en   = 1'b1;
        lw_addr = wprev_r;
        lw_data = link_q_r;
      end
      if (tail_rd == wcur_r) begin
        lt_we   = 1'b1;
        lt_data = wprev_r;
      end
      if (!free_count_r[IW-1]) begin
        fw_en          = 1'b1;
        free_count_nxt = free_count_r + IW'(1);
        if (!wr_fill_r[IW-1]) wr_fill_nxt = wr_fill_r + IW'(1);
      end
    end
    if (cmd.nxt_adv) begin
      wcur_nxt = link_q_r;
      wn_nxt   = wn_r + IW'(1);
    end
    if (cmd.nxt_lvl) begin
      cur_lvl_nxt = cur_lvl_r + LW'(1);
      cur_ent_nxt = '0;
    end
    if (cmd.cur_clear) begin
      cur_lvl_nxt = '0;
      cur_ent_nxt = '0;
    end
    if (cmd.flag_set) flag_nxt = 1'b1;
    if (cmd.emit && cmd.kind == lia_pkg::RK_NXT_HIT) cur_ent_nxt = cur_ent_r + IW'(1);
    if (cmd.emit && cmd.kind == lia_pkg::RK_END) flag_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= '0;
      free_count_r <= IW'(lia_pkg::NUM_IDS);
      wr_fill_r    <= '0;
      cur_lvl_r    <= '0;
      cur_ent_r    <= '0;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < lia_pkg::NUM_LEVELS; i++) begin
        lhead_r[i] <= '0;
        ltail_r[i] <= '0;
      end
    end else begin
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      wr_fill_r    <= wr_fill_nxt;
      cur_lvl_r    <= cur_lvl_nxt;
      cur_ent_r    <= cur_ent_nxt;
      flag_r       <= flag_nxt;
      out_valid_r  <= cmd.emit;
      if (lh_we) lhead_r[lvl_r] <= lh_data;
      if (lt_we) ltail_r[lvl_r] <= lt_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      lvl_r <= in_level;
      id_r  <= in_item_id;
    end
    wcur_r    <= wcur_nxt;
    wprev_r   <= wprev_nxt;
    wn_r      <= wn_nxt;
    nid_r     <= nid_nxt;
    out_rdy_r <= flag_nxt;
    case (cmd.kind)
      lia_pkg::RK_ADD: begin
        out_id_r   <= nid_r;
        out_hit_r  <= 1'b0;
        out_ferr_r <= 1'b0;
        out_end_r  <= 1'b0;
      end
      lia_pkg::RK_FERR: begin
        out_id_r   <= '0;
        out_hit_r  <= 1'b0;
        out_ferr_r <= 1'b1;
        out_end_r  <= 1'b0;
      end
      lia_pkg::RK_REM_HIT: begin
        out_id_r   <= '0;
        out_hit_r  <= 1'b1;
        out_ferr_r <= 1'b0;
        out_end_r  <= 1'b0;
      end
      lia_pkg::RK_NXT_HIT: begin
        out_id_r   <= wcur_r;
        out_hit_r  <= 1'b1;
        out_ferr_r <= 1'b0;
        out_end_r  <= 1'b0;
      end
      lia_pkg::RK_END: begin
        out_id_r   <= '0;
        out_hit_r  <= 1'b0;
        out_ferr_r <= 1'b0;
        out_end_r  <= 1'b1;
      end
      default: begin
        out_id_r   <= '0;
        out_hit_r  <= 1'b0;
        out_ferr_r <= 1'b0;
        out_end_r  <= 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fw_en) fifo_mem[fw_idx] <= wcur_r;
    fifo_q_r   <= fifo_mem[free_head_r];
    fq_idx_r   <= free_head_r;
    fq_valid_r <= ({1'b0, free_head_r} < wr_fill_r);
  end

  always_ff @(posedge clk) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    link_q_r <= link_mem[wcur_r];
  end

  assign out_valid       = out_valid_r;
  assign out_result_id   = out_id_r;
  assign out_hit         = out_hit_r;
  assign out_full_error  = out_ferr_r;
  assign out_end_reached = out_end_r;
  assign out_ready_flag  = out_rdy_r;

endmodule

FILE: rtl/layered_id_allocator_list.sv
// Channel   Ports                                          Handshake
// input     in_op, in_level, in_item_id                    taken when start && !busy
// result    out_result_id, out_hit, out_full_error,        one cycle, marked by out_valid
//           out_end_reached, out_ready_flag
//
// Sequence: start, mark, odd opcodes, a full add and a remove of a bad ID finish at dispatch;
//   add then links the new ID. Remove reads and checks each entry up to the match or the end
//   of the list. Next walks each entry skipped and each level passed, and each walk step
//   waits on one registered link read.
// Reset: rst_n low for one clock; the free ring starts full without a clearing pass.
// Stalls: busy stays high until the result is driven; the receiver cannot stall.
module layered_id_allocator_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [lia_pkg::OP_W-1:0]  in_op,
  input  logic [lia_pkg::LVL_W-1:0] in_level,
  input  logic [lia_pkg::ID_W-1:0]  in_item_id,
  output logic                      out_valid,
  output logic [lia_pkg::ID_W-1:0]  out_result_id,
  output logic                      out_hit,
  output logic                      out_full_error,
  output logic                      out_end_reached,
  output logic                      out_ready_flag
);

  // Commands flow down from the sequencer, status flows back up.
  lia_pkg::cmd_t cmd;
  lia_pkg::sts_t sts;

  // Sequence each op: dispatch, walk lists, emit the result.
  lia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the free ring, link memory, level heads and tails, and the cursor.
  lia_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_level        (in_level),
    .in_item_id      (in_item_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_result_id   (out_result_id),
    .out_hit         (out_hit),
    .out_full_error  (out_full_error),
    .out_end_reached (out_end_reached),
    .out_ready_flag  (out_ready_flag)
  );

endmodule

FILE: rtl/lia_chk.sv
module lia_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [lia_pkg::ID_W-1:0]  out_result_id,
  input logic                      out_hit,
  input logic                      out_full_error,
  input logic                      out_end_reached,
  input logic                      out_ready_flag
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result driven while busy");

  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on back-to-back cycles");

  a_ferr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_error |-> out_result_id == '0 && !out_hit)
    else $error("full error with an ID");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_reached |-> !out_ready_flag && !out_hit)
    else $error("end with flag or hit set");

endmodule

bind layered_id_allocator_list lia_chk u_lia_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_id   (out_result_id),
  .out_hit         (out_hit),
  .out_full_error  (out_full_error),
  .out_end_reached (out_end_reached),
  .out_ready_flag  (out_ready_flag)
);
